// ===== sv/ssr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Seven-segment string renderer package
// Character codes, glyph patterns and the image and context types that the
// decode stage and the top level share.
// ----------------------------------------------------------------------------
package ssr_pkg;

	localparam int NUM_DIGITS = 6;
	localparam int POS_W      = 3;   // holds 0..NUM_DIGITS
	localparam int SEG_W      = 7;
	localparam int POINTS     = 4;

	// Character codes that the decoder recognises.
	localparam logic [7:0] CH_ZERO    = 8'd48;
	localparam logic [7:0] CH_NINE    = 8'd57;
	localparam logic [7:0] CH_POINT   = 8'd46;
	localparam logic [7:0] CH_LOWER_C = 8'h63;
	localparam logic [7:0] CH_LOWER_P = 8'h70;
	localparam logic [7:0] CH_PERCENT = 8'h25;

	// Glyph codes beyond the decimal digits.
	localparam logic [3:0] GLYPH_C = 4'd10;
	localparam logic [3:0] GLYPH_P = 4'd11;

	typedef logic [SEG_W-1:0] seg_t;

	typedef struct packed {
		seg_t [NUM_DIGITS-1:0] segs;
		logic [POINTS-1:0]     points;
		logic                  degree;
		logic                  percent;
		logic [POS_W-1:0]      pos;
	} image_t;

	// Facts about the string index that the decoder needs.
	typedef struct packed {
		logic       first;      // first character of a string
		logic       point_ok;   // index lies in the range that may carry a point
		logic [1:0] point_sel;  // which decimal point a '.' lights
	} ctx_t;

	// Segment pattern, bit0 = a through bit6 = g.
	function automatic seg_t glyph(input logic [3:0] code);
		seg_t g;
		unique case (code)
			4'd0:    g = 7'h3F;
			4'd1:    g = 7'h06;
			4'd2:    g = 7'h5B;
			4'd3:    g = 7'h4F;
			4'd4:    g = 7'h66;
			4'd5:    g = 7'h6D;
			4'd6:    g = 7'h7D;
			4'd7:    g = 7'h07;
			4'd8:    g = 7'h7F;
			4'd9:    g = 7'h6F;
			GLYPH_C: g = 7'h39;
			GLYPH_P: g = 7'h73;
			default: g = '0;
		endcase
		return g;
	endfunction

endpackage

// ===== sv/ssr_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Seven-segment string renderer channels
// Valid/ready channels for the character input and the rendered image output.
// ----------------------------------------------------------------------------
interface ssr_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] character;

	modport source (output valid, output character, input ready);
	modport sink   (input valid, input character, output ready);
endinterface

interface ssr_image_if;
	logic       valid;
	logic       ready;
	logic [6:0] digit0_segments;
	logic [6:0] digit1_segments;
	logic [6:0] digit2_segments;
	logic [6:0] digit3_segments;
	logic [6:0] digit4_segments;
	logic [6:0] digit5_segments;
	logic [3:0] point_marks;
	logic       degree_mark;
	logic       percent_mark;
	logic       string_done;

	modport source (
		output valid, output digit0_segments, output digit1_segments,
		output digit2_segments, output digit3_segments, output digit4_segments,
		output digit5_segments, output point_marks, output degree_mark,
		output percent_mark, output string_done, input ready
	);
	modport sink (
		input valid, input digit0_segments, input digit1_segments,
		input digit2_segments, input digit3_segments, input digit4_segments,
		input digit5_segments, input point_marks, input degree_mark,
		input percent_mark, input string_done, output ready
	);
endinterface

// ===== sv/seven_segment_string_renderer_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Seven-segment string renderer
// Builds a six-digit seven-segment image from strings of characters.
// ----------------------------------------------------------------------------
// Usage: characters arrive one per beat on the text channel, grouped into
// strings of STRING_LENGTH characters. Every accepted character yields one
// beat on the display channel carrying the whole image as it stands after
// that character, with string_done set on the last character of a string.
// The first character of each string blanks the image before it is drawn.
// The result is registered: a character accepted is presented in the
// cycle after. Throughput is one character per cycle unless the display
// side stalls, set by the single decode stage between the string state
// and the result register. While a result waits, text.ready stays high
// when the receiver takes that result in the same cycle; if the display
// side stalls, the result holds and text.ready falls until it is taken.
// Reset clears the string index, the digit position, the image and the
// result valid, so the first character after reset starts a new string.
// ----------------------------------------------------------------------------
module seven_segment_string_renderer_unit #(
	parameter int STRING_LENGTH = 7
) (
	input  logic        clk,
	input  logic        arst_n,
	ssr_char_if.sink    text,
	ssr_image_if.source display
);
	import ssr_pkg::*;

	localparam int IDX_W = $clog2(STRING_LENGTH);

	// String state, updated as each character is accepted.
	logic [IDX_W-1:0] idx_q;
	image_t           image_q;

	// Result register.
	logic             out_valid_q;
	image_t           out_image_q;
	logic             out_done_q;

	logic             accept;
	logic             last;
	logic [IDX_W-1:0] idx_m1;
	ctx_t             ctx;
	image_t           image_next;

	// A new character may enter whenever the result register is empty or is
	// being emptied in this cycle.
	assign text.ready = !out_valid_q || display.ready;
	assign accept     = text.valid && text.ready;

	// Index facts for the decoder: a point is honoured at indices one to four
	// and lights the point to the left of its index.
	always_comb begin
		idx_m1        = idx_q - IDX_W'(1);
		last          = (idx_q == IDX_W'(STRING_LENGTH - 1));
		ctx.first     = (idx_q == '0);
		ctx.point_ok  = (idx_q >= IDX_W'(1)) && (idx_q <= IDX_W'(4));
		ctx.point_sel = idx_m1[1:0];
	end

	ssr_decode u_decode (
		.character (text.character),
		.ctx       (ctx),
		.cur       (image_q),
		.nxt       (image_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			image_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				idx_q   <= last ? '0 : idx_q + IDX_W'(1);
				image_q <= image_next;
			end
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (display.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result payload needs no reset; it is only looked at while valid.
	always_ff @(posedge clk) begin
		if (accept) begin
			out_image_q <= image_next;
			out_done_q  <= last;
		end
	end

	assign display.valid           = out_valid_q;
	assign display.digit0_segments = out_image_q.segs[0];
	assign display.digit1_segments = out_image_q.segs[1];
	assign display.digit2_segments = out_image_q.segs[2];
	assign display.digit3_segments = out_image_q.segs[3];
	assign display.digit4_segments = out_image_q.segs[4];
	assign display.digit5_segments = out_image_q.segs[5];
	assign display.point_marks     = out_image_q.points;
	assign display.degree_mark     = out_image_q.degree;
	assign display.percent_mark    = out_image_q.percent;
	assign display.string_done     = out_done_q;

endmodule

// ===== sv/ssr_decode.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Seven-segment string renderer character decoder
// Classifies one character and derives the next image from the current one.
// ----------------------------------------------------------------------------
module ssr_decode (
	input  logic [7:0]      character,
	input  ssr_pkg::ctx_t   ctx,
	input  ssr_pkg::image_t cur,
	output ssr_pkg::image_t nxt
);
	import ssr_pkg::*;

	image_t     base;
	logic       is_digit;
	logic       is_c;
	logic       is_p;
	logic       is_point;
	logic       is_pct;
	logic       draw;
	logic       on_screen;
	logic [3:0] code;
	logic [7:0] digit_off;
	seg_t       pattern;

	always_comb begin
		// The first character of a string starts from a blank image.
		base = cur;
		if (ctx.first) begin
			base = '0;
		end

		digit_off = character - CH_ZERO;
		is_digit  = (character >= CH_ZERO) && (character <= CH_NINE);
		is_c      = (character == CH_LOWER_C);
		is_p      = (character == CH_LOWER_P);
		is_point  = (character == CH_POINT) && ctx.point_ok;
		is_pct    = (character == CH_PERCENT);
		draw      = is_digit || is_c || is_p;

		code = GLYPH_P;
		if (is_digit) begin
			code = digit_off[3:0];
		end else if (is_c) begin
			code = GLYPH_C;
		end
		pattern = glyph(code);

		on_screen = (base.pos < POS_W'(NUM_DIGITS));

		nxt = base;
		for (int k = 0; k < NUM_DIGITS; k++) begin
			if (draw && (base.pos == POS_W'(k))) begin
				nxt.segs[k] = base.segs[k] | pattern;
			end
		end
		if (is_point) begin
			nxt.points[ctx.point_sel] = 1'b1;
		end
		if (is_c) begin
			nxt.degree = 1'b1;
		end
		if (is_pct) begin
			nxt.percent = 1'b1;
		end
		// Everything but a mark moves on one position, saturating past the
		// last digit.
		if (!(is_point || is_pct) && on_screen) begin
			nxt.pos = base.pos + POS_W'(1);
		end
	end

endmodule
